### sv/sliding_window_mean_min_max_macros.svh
// Assertion macros used by the checker file swmmm_checker.sv
`ifndef SLIDING_WINDOW_MEAN_MIN_MAX_MACROS_SVH
`define SLIDING_WINDOW_MEAN_MIN_MAX_MACROS_SVH

// same-cycle implication
`define SWMMM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SWMMM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/swmmm_pkg.sv
`timescale 1ns / 1ps

package swmmm_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int HELD_W     = 5;
    localparam int WINDOW_DEF = 20;

    // result packing, lowest bit first
    localparam int AVG_LSB  = 0;
    localparam int MIN_LSB  = AVG_LSB + SAMPLE_W;
    localparam int MAX_LSB  = MIN_LSB + SAMPLE_W;
    localparam int HELD_LSB = MAX_LSB + SAMPLE_W;
    localparam int RES_W    = HELD_LSB + HELD_W;
    localparam int OUT_W    = ((RES_W + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_OLD,
        ST_UPDATE,
        ST_SCAN,
        ST_SCAN_TAIL,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_sample;
        logic rd_old;
        logic update;
        logic scan_init;
        logic scan_rd;
        logic div_init;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
        logic div_last;
    } status_t;

endpackage

### sv/swmmm_datapath.sv
`timescale 1ns / 1ps

module swmmm_datapath #(
    parameter int WINDOW = swmmm_pkg::WINDOW_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  swmmm_pkg::cmd_t               cmd,
    output swmmm_pkg::status_t            status,
    input  logic [swmmm_pkg::SAMPLE_W-1:0] sample,
    output logic [swmmm_pkg::SAMPLE_W-1:0] average,
    output logic [swmmm_pkg::SAMPLE_W-1:0] smallest,
    output logic [swmmm_pkg::SAMPLE_W-1:0] largest,
    output logic [swmmm_pkg::HELD_W-1:0]   held
);

    localparam int SW  = swmmm_pkg::SAMPLE_W;
    localparam int AW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW  = $clog2(WINDOW + 1);
    localparam int TW  = SW + CW;
    localparam int DCW = $clog2(TW);

    logic [SW-1:0]  mem [WINDOW];
    logic [SW-1:0]  rdata_reg;
    logic [AW-1:0]  rd_addr;

    logic [SW-1:0]  sample_reg;
    logic [AW-1:0]  slot_reg;
    logic [CW-1:0]  count_reg;
    logic [TW-1:0]  total_reg;
    logic [AW-1:0]  scan_idx_reg;
    logic           scan_pend_reg;
    logic           scan_first_reg;
    logic [SW-1:0]  lo_reg;
    logic [SW-1:0]  hi_reg;
    logic [TW-1:0]  quo_reg;
    logic [CW-1:0]  rem_reg;
    logic [DCW-1:0] div_cnt_reg;
    logic [SW-1:0]  avg_out_reg;
    logic [SW-1:0]  lo_out_reg;
    logic [SW-1:0]  hi_out_reg;
    logic [swmmm_pkg::HELD_W-1:0] held_out_reg;

    logic           full;
    logic [TW-1:0]  total_next;
    logic [CW:0]    trial;
    logic           trial_ge;
    logic [CW:0]    trial_diff;

    assign full    = (count_reg == CW'(WINDOW));
    assign rd_addr = cmd.rd_old ? slot_reg : scan_idx_reg;

    // old sample is only meaningful once the window is full
    assign total_next = total_reg + TW'(sample_reg)
                      - (full ? TW'(rdata_reg) : TW'(0));

    assign trial      = {rem_reg, quo_reg[TW-1]};
    assign trial_ge   = (trial >= {1'b0, count_reg});
    assign trial_diff = trial - {1'b0, count_reg};

    assign status.scan_last = (CW'(scan_idx_reg) == count_reg - CW'(1));
    assign status.div_last  = (div_cnt_reg == DCW'(TW - 1));

    // ring store, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            mem[slot_reg] <= sample_reg;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            count_reg     <= '0;
            total_reg     <= '0;
            scan_idx_reg  <= '0;
            scan_pend_reg <= 1'b0;
        end
        else
        begin
            scan_pend_reg <= cmd.scan_rd;
            if (cmd.update)
            begin
                total_reg <= total_next;
                if (!full)
                begin
                    count_reg <= count_reg + CW'(1);
                end
                slot_reg <= (slot_reg == AW'(WINDOW - 1)) ? '0 : slot_reg + AW'(1);
            end
            if (cmd.scan_init)
            begin
                scan_idx_reg <= '0;
            end
            else if (cmd.scan_rd)
            begin
                scan_idx_reg <= scan_idx_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
        begin
            sample_reg <= sample;
        end
        if (cmd.scan_init)
        begin
            scan_first_reg <= 1'b1;
        end
        else if (scan_pend_reg)
        begin
            scan_first_reg <= 1'b0;
        end
        if (scan_pend_reg)
        begin
            if (scan_first_reg || rdata_reg < lo_reg)
            begin
                lo_reg <= rdata_reg;
            end
            if (scan_first_reg || rdata_reg > hi_reg)
            begin
                hi_reg <= rdata_reg;
            end
        end
        // restoring divide, one quotient bit per cycle
        if (cmd.div_init)
        begin
            quo_reg     <= total_reg;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg     <= {quo_reg[TW-2:0], trial_ge};
            rem_reg     <= trial_ge ? trial_diff[CW-1:0] : trial[CW-1:0];
            div_cnt_reg <= div_cnt_reg + DCW'(1);
        end
        if (cmd.out_load)
        begin
            avg_out_reg  <= quo_reg[SW-1:0];
            lo_out_reg   <= lo_reg;
            hi_out_reg   <= hi_reg;
            held_out_reg <= swmmm_pkg::HELD_W'(count_reg);
        end
    end

    assign average  = avg_out_reg;
    assign smallest = lo_out_reg;
    assign largest  = hi_out_reg;
    assign held     = held_out_reg;

endmodule

### sv/swmmm_ctrl.sv
`timescale 1ns / 1ps

module swmmm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  swmmm_pkg::status_t  status,
    output swmmm_pkg::cmd_t     cmd
);

    swmmm_pkg::state_t state_reg;
    swmmm_pkg::state_t state_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= swmmm_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            swmmm_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_sample = 1'b1;
                    state_next      = swmmm_pkg::ST_RD_OLD;
                end
            end
            swmmm_pkg::ST_RD_OLD:
            begin
                cmd.rd_old = 1'b1;
                state_next = swmmm_pkg::ST_UPDATE;
            end
            swmmm_pkg::ST_UPDATE:
            begin
                cmd.update    = 1'b1;
                cmd.scan_init = 1'b1;
                state_next    = swmmm_pkg::ST_SCAN;
            end
            swmmm_pkg::ST_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (status.scan_last)
                begin
                    state_next = swmmm_pkg::ST_SCAN_TAIL;
                end
            end
            swmmm_pkg::ST_SCAN_TAIL:
            begin
                // last scan word is compared this cycle
                cmd.div_init = 1'b1;
                state_next   = swmmm_pkg::ST_DIV;
            end
            swmmm_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = swmmm_pkg::ST_DONE;
                end
            end
            swmmm_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = swmmm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swmmm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

### sv/sliding_window_mean_min_max.sv
`timescale 1ns / 1ps
// From accept to result valid: a WINDOW-independent setup, then the ring scan and
//   the divide. A new request is taken only once the last result is loaded.
// The work is paced by the one-port ring scan (one sample a cycle) and the
//   one-bit-per-cycle restoring divider.
// A result waiting in the output register does not block the next request.
// Reset (rst_n, async, active low) empties the window; ring contents stay undefined.

module sliding_window_mean_min_max #(
    parameter int WINDOW = swmmm_pkg::WINDOW_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,   // sample[31:0]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [swmmm_pkg::OUT_W-1:0] m_tdata    // average, smallest, largest, held, pad
);

    swmmm_pkg::cmd_t    cmd;
    swmmm_pkg::status_t status;

    logic [swmmm_pkg::SAMPLE_W-1:0] average;
    logic [swmmm_pkg::SAMPLE_W-1:0] smallest;
    logic [swmmm_pkg::SAMPLE_W-1:0] largest;
    logic [swmmm_pkg::HELD_W-1:0]   held;

    swmmm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    swmmm_datapath #(
        .WINDOW (WINDOW)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .sample   (s_tdata),
        .average  (average),
        .smallest (smallest),
        .largest  (largest),
        .held     (held)
    );

    assign m_tdata = swmmm_pkg::OUT_W'({held, largest, smallest, average});

endmodule

### sv/swmmm_checker.sv
`timescale 1ns / 1ps
`include "sliding_window_mean_min_max_macros.svh"

module swmmm_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [swmmm_pkg::OUT_W-1:0] m_tdata
);

    logic [31:0] avg_f;
    logic [31:0] min_f;
    logic [31:0] max_f;

    assign avg_f = m_tdata[swmmm_pkg::AVG_LSB +: 32];
    assign min_f = m_tdata[swmmm_pkg::MIN_LSB +: 32];
    assign max_f = m_tdata[swmmm_pkg::MAX_LSB +: 32];

    `SWMMM_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `SWMMM_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, s_tvalid && s_tready, !s_tready, "second request taken during processing")
    `SWMMM_ASSERT_NOW(a_min_le_max, clk, rst_n, m_tvalid, min_f <= max_f, "smallest above largest")
    `SWMMM_ASSERT_NOW(a_avg_range, clk, rst_n, m_tvalid, (avg_f >= min_f) && (avg_f <= max_f), "average outside window range")

endmodule

bind sliding_window_mean_min_max swmmm_checker u_swmmm_checker (.*);
